FILE: sv/brfs_pkg.sv
// brfs_pkg: shared types and constants for the byte ring fifo with search
// no dependencies; imported by brfs_cell and byte_ring_fifo_with_search
`timescale 1ns / 1ps

package brfs_pkg;

	// default number of byte cells in the chain
	localparam int DEPTH_DEF = 256;

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int DIST_W = 8;
	localparam int FREE_W = 9;
	localparam int MODE_W = 2;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;    // tail cell loads the write byte
		logic pop;     // every cell takes its right neighbor
		logic rotate;  // occupied cells rotate one place, head wraps to tail
	} cell_ctrl_t;

endpackage

FILE: sv/brfs_cell.sv
// brfs_cell: one byte cell of the fifo chain
// depends on brfs_pkg for the command struct and byte width
`timescale 1ns / 1ps

module brfs_cell #(
	parameter int DEPTH = brfs_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                           clk,
	input  brfs_pkg::cell_ctrl_t           ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]     count,
	input  logic [brfs_pkg::BYTE_W-1:0]    wr_byte,
	input  logic [brfs_pkg::BYTE_W-1:0]    next_byte,
	input  logic [brfs_pkg::BYTE_W-1:0]    head_byte,
	output logic [brfs_pkg::BYTE_W-1:0]    byte_q
);
	import brfs_pkg::*;

	localparam int CW = $clog2(DEPTH+1);

	logic at_tail;
	logic at_last;

	// first free cell, and last occupied cell
	assign at_tail = (count == CW'(IDX));
	assign at_last = (count == CW'(IDX + 1));

	always_ff @(posedge clk) begin
		if (ctrl.push && at_tail) begin
			byte_q <= wr_byte;
		end else if (ctrl.pop) begin
			byte_q <= next_byte;
		end else if (ctrl.rotate) begin
			byte_q <= at_last ? head_byte : next_byte;
		end
	end

endmodule

FILE: sv/byte_ring_fifo_with_search.sv
// byte_ring_fifo_with_search: byte fifo built as a chain of shifting cells with a
// rotating search; depends on brfs_pkg and brfs_cell
//
// channel | signals                               | direction
// --------+---------------------------------------+----------
// in      | in_valid, in_stall, mode, data_byte   | into block
// out     | out_valid, out_stall, op_ok,          | out of block
//         | read_byte, match_found,               |
//         | match_distance, is_full, is_empty,    |
//         | free_space                            |
//
// push, pop and the unused code can stream at one per cycle while out_stall is low
// a search on an empty fifo answers with no match without stalling; otherwise it holds
// the input stalled while each occupied cell rotates in turn past cell 0, where the
// compare sits, and the cells come back to their order after a full turn
// reset (arst_n low) empties the fifo, ends any search and drops a waiting result;
// cell contents are not reset
// a result waiting under out_stall holds the input stalled until it is taken
`timescale 1ns / 1ps

module byte_ring_fifo_with_search #(
	parameter int DEPTH = brfs_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [brfs_pkg::MODE_W-1:0]   mode,
	input  logic [brfs_pkg::BYTE_W-1:0]   data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          op_ok,
	output logic [brfs_pkg::BYTE_W-1:0]   read_byte,
	output logic                          match_found,
	output logic [brfs_pkg::DIST_W-1:0]   match_distance,
	output logic                          is_full,
	output logic                          is_empty,
	output logic [brfs_pkg::FREE_W-1:0]   free_space
);
	import brfs_pkg::*;

	localparam int CW = $clog2(DEPTH+1);  // occupancy, 0..DEPTH
	localparam int IW = $clog2(DEPTH);    // search step, 0..DEPTH-1

	// controller states
	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic                state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic [IW-1:0]       step_q;
	logic [BYTE_W-1:0]   char_q;
	logic                found_q;
	logic [DIST_W-1:0]   dist_q;

	logic                out_valid_q;
	logic                op_ok_q;
	logic [BYTE_W-1:0]   read_byte_q;
	logic                match_found_q;
	logic [DIST_W-1:0]   match_distance_q;
	logic                is_full_q;
	logic                is_empty_q;
	logic [FREE_W-1:0]   free_space_q;

	cell_ctrl_t          ctrl;
	logic                in_acc;
	logic                fifo_full;
	logic                fifo_empty;
	logic                hit;
	logic                last_step;
	logic                load_res;
	logic                start_search;
	logic                res_ok;
	logic [BYTE_W-1:0]   res_rd;
	logic                res_found;
	logic [DIST_W-1:0]   res_dist;
	logic [CW-1:0]       free_nxt;

	logic [BYTE_W-1:0]   cell_byte [DEPTH];

	// the chain of byte cells, cell 0 holds the oldest byte
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [BYTE_W-1:0] nb;
		if (i == DEPTH - 1) begin : g_end
			assign nb = cell_byte[i];
		end else begin : g_mid
			assign nb = cell_byte[i+1];
		end
		brfs_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.wr_byte   (data_byte),
			.next_byte (nb),
			.head_byte (cell_byte[0]),
			.byte_q    (cell_byte[i])
		);
	end

	// new transaction only when idle and the result slot is free or draining
	assign in_stall   = (state_q != ST_IDLE) | (out_valid_q & out_stall);
	assign in_acc     = in_valid & ~in_stall;
	assign fifo_full  = (count_q == CW'(DEPTH));
	assign fifo_empty = (count_q == '0);

	// compare sits on the head cell; the last rotation restores the order
	assign hit       = (cell_byte[0] == char_q);
	assign last_step = ((CW'(step_q) + CW'(1)) == count_q);

	always_comb begin
		ctrl         = '0;
		load_res     = 1'b0;
		start_search = 1'b0;
		count_nxt    = count_q;
		res_ok       = 1'b0;
		res_rd       = '0;
		res_found    = 1'b0;
		res_dist     = '0;
		if (state_q == ST_SEARCH) begin
			ctrl.rotate = 1'b1;
			if (last_step) begin
				load_res  = 1'b1;
				res_found = found_q | hit;
				res_dist  = found_q ? dist_q : (hit ? DIST_W'(step_q) : '0);
				res_ok    = res_found;
			end
		end else if (in_acc) begin
			load_res = 1'b1;
			case (mode)
				MODE_PUSH: begin
					if (!fifo_full) begin
						ctrl.push = 1'b1;
						count_nxt = count_q + CW'(1);
						res_ok    = 1'b1;
					end
				end
				MODE_POP: begin
					if (!fifo_empty) begin
						ctrl.pop  = 1'b1;
						count_nxt = count_q - CW'(1);
						res_ok    = 1'b1;
						res_rd    = cell_byte[0];
					end
				end
				MODE_SEARCH: begin
					// an empty fifo answers at once with no match
					if (!fifo_empty) begin
						load_res     = 1'b0;
						start_search = 1'b1;
					end
				end
				default: begin
					// unused code: no operation, status only
				end
			endcase
		end
	end

	assign free_nxt = CW'(DEPTH) - count_nxt;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (start_search) begin
				state_q <= ST_SEARCH;
			end else if (load_res) begin
				state_q <= ST_IDLE;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search bookkeeping
	always_ff @(posedge clk) begin
		if (start_search) begin
			char_q  <= data_byte;
			step_q  <= '0;
			found_q <= 1'b0;
			dist_q  <= '0;
		end else if (state_q == ST_SEARCH) begin
			step_q <= step_q + IW'(1);
			if (hit && !found_q) begin
				found_q <= 1'b1;
				dist_q  <= DIST_W'(step_q);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_res) begin
			op_ok_q          <= res_ok;
			read_byte_q      <= res_rd;
			match_found_q    <= res_found;
			match_distance_q <= res_dist;
			is_full_q        <= (count_nxt == CW'(DEPTH));
			is_empty_q       <= (count_nxt == '0);
			free_space_q     <= FREE_W'(free_nxt);
		end
	end

	assign out_valid      = out_valid_q;
	assign op_ok          = op_ok_q;
	assign read_byte      = read_byte_q;
	assign match_found    = match_found_q;
	assign match_distance = match_distance_q;
	assign is_full        = is_full_q;
	assign is_empty       = is_empty_q;
	assign free_space     = free_space_q;

`ifndef SYNTH
	// a search only starts with the result slot free or draining, and the slot stays empty during it
	a_search_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !out_valid_q)
		else $error("result pending during search");

	// occupancy never passes the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy overflow");

	// an accepted push into a non-full fifo grows it by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode == MODE_PUSH && !fifo_full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not advance occupancy");

	// a search step counter stays below the occupancy
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (CW'(step_q) < count_q))
		else $error("search ran past occupied cells");
`endif

endmodule
